// File: rtl/rle_runs_to_fill_rectangles_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the run-length to fill-rectangle converter
// Shorthand for clocked implications used by the RTL assertions.
// ----------------------------------------------------------------------------
`ifndef RLE_RUNS_TO_FILL_RECTANGLES_TOP_DEFINES_SVH
`define RLE_RUNS_TO_FILL_RECTANGLES_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RLERECT_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("rlerect assertion failed");

// Next-cycle implication, checked outside reset.
`define RLERECT_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("rlerect assertion failed");

`endif

// File: rtl/rlerect_pkg.sv
// ----------------------------------------------------------------------------
// Run-length to fill-rectangle converter package
// Widths, register indexes, reset values and the divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package rlerect_pkg;

  localparam int TOTAL_W  = 32;
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 16;
  localparam int RUN_W    = 16;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(TOTAL_W);

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BASE   = 2'd2;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 10'd480;

  typedef struct packed {
    logic               start;
    logic [TOTAL_W-1:0] dividend;
    logic [CFG_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
    logic [CFG_W-1:0]   rem;
  } div_res_t;

endpackage

`default_nettype wire

// File: rtl/rlerect_if.sv
// ----------------------------------------------------------------------------
// Run-length converter stream interfaces
// Valid/ready channels for run records in and fill rectangles out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlerect_run_if import rlerect_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               start_image;
  logic [COLOR_W-1:0] pixel_color;
  logic [RUN_W-1:0]   run_length;

  modport source (output valid, start_image, pixel_color, run_length, input ready);
  modport sink (input valid, start_image, pixel_color, run_length, output ready);
endinterface

interface rlerect_rect_if import rlerect_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;
  logic [COORD_W-1:0] x_end;
  logic [COORD_W-1:0] y_end;
  logic [COLOR_W-1:0] fill_color;
  logic               last_rect;

  modport source (output valid, x_start, y_start, x_end, y_end, fill_color, last_rect,
                  input ready);
  modport sink (input valid, x_start, y_start, x_end, y_end, fill_color, last_rect,
                output ready);
endinterface

`default_nettype wire

// File: rtl/rlerect_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of the pixel total by the line width, one quotient bit
// per cycle; returns the low quotient bits and the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rlerect_div import rlerect_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_res_t      res
);

  logic [TOTAL_W-1:0]   dvd;
  logic [CFG_W-1:0]     dvs;
  logic [CFG_W-1:0]     rem;
  logic [COORD_W-1:0]   quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [CFG_W:0] trial;
  logic           ge;
  logic [CFG_W:0] diff;

  always_comb begin
    trial = {rem, dvd[TOTAL_W-1]};
    ge    = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= DIV_CNT_W'(TOTAL_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        dvd  <= {dvd[TOTAL_W-2:0], 1'b0};
        rem  <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        quot <= {quot[COORD_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

`default_nettype wire

// File: rtl/rle_runs_to_fill_rectangles_top.sv
// ----------------------------------------------------------------------------
// Run-length to fill-rectangle converter
// Turns RGB565 run records into one to three inclusive fill rectangles each.
//
//   Channel | Direction | Payload
//   run     | sink      | start_image, pixel_color, run_length
//   rect    | source    | x_start, y_start, x_end, y_end, fill_color, last_rect
//   cfg     | write     | line_width, column base, row base
//
// Each run is taken in S_IDLE, then split in S_DIVIDE by the bit-serial divider, which
// divides the 32-bit pixel total into row and column, and then sent out one rectangle
// at a time in S_EMIT. A stalled rect channel holds the sequencer in place.
// Reset is synchronous; it clears the pixel total and position and loads
// the register reset values. A run is taken only while no run is in work.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rle_runs_to_fill_rectangles_top_defines.svh"

module rle_runs_to_fill_rectangles_top import rlerect_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  rlerect_run_if.sink               run,
  rlerect_rect_if.source            rect
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_EMIT
  } state_t;

  state_t state;

  logic [CFG_W-1:0]   line_width;
  logic [CFG_W-1:0]   col_base;
  logic [CFG_W-1:0]   row_base;
  logic [TOTAL_W-1:0] total;
  logic [COORD_W-1:0] prev_col;
  logic [COORD_W-1:0] prev_row;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] edge_col;
  logic [COLOR_W-1:0] color;
  logic [1:0]         k;

  logic               run_xfer;
  logic [CFG_W-1:0]   w_eff;
  logic [TOTAL_W-1:0] total_next;
  logic [1:0]         n_last;
  logic               is_last;
  logic               out_free;
  logic [COORD_W-1:0] r_xs;
  logic [COORD_W-1:0] r_ys;
  logic [COORD_W-1:0] r_xe;
  logic [COORD_W-1:0] r_ye;
  logic [COORD_W-1:0] xo16;

  div_req_t div_req;
  div_res_t div_res;

  assign run.ready = (state == S_IDLE);
  assign run_xfer  = run.valid && run.ready;
  assign w_eff     = (line_width == '0) ? CFG_W'(1) : line_width;
  assign xo16      = COORD_W'(col_base);
  assign out_free  = !rect.valid || rect.ready;

  always_comb begin
    total_next = (run.start_image ? '0 : total) + TOTAL_W'(run.run_length);
    div_req.start    = run_xfer;
    div_req.dividend = total_next;
    div_req.divisor  = w_eff;
  end

  rlerect_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_comb begin
    if (row > prev_row) begin
      if ({1'b0, row} > ({1'b0, prev_row} + 17'd1)) begin
        n_last = 2'd2;
      end else begin
        n_last = 2'd1;
      end
    end else begin
      n_last = 2'd0;
    end
    is_last = (k == n_last);
    if (is_last) begin
      r_xs = (n_last == 2'd0) ? prev_col : xo16;
      r_ys = (n_last == 2'd0) ? prev_row : row;
      r_xe = col;
      r_ye = row;
    end else if (k == 2'd0) begin
      r_xs = prev_col;
      r_ys = prev_row;
      r_xe = edge_col;
      r_ye = (n_last == 2'd1) ? row - 16'd1 : prev_row;
    end else begin
      r_xs = xo16;
      r_ys = prev_row + 16'd1;
      r_xe = edge_col;
      r_ye = row - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      col_base   <= '0;
      row_base   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LINE_WIDTH: line_width <= cfg_data;
        CFG_COL_BASE:   col_base   <= cfg_data;
        CFG_ROW_BASE:   row_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      prev_col   <= '0;
      prev_row   <= '0;
      k          <= '0;
      rect.valid <= 1'b0;
    end else begin
      if (rect.valid && rect.ready && state != S_EMIT) begin
        rect.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (run_xfer) begin
            total    <= total_next;
            color    <= run.pixel_color;
            edge_col <= COORD_W'(w_eff) - 16'd1 + xo16;
            if (run.start_image) begin
              prev_col <= xo16;
              prev_row <= COORD_W'(row_base);
            end
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_res.done) begin
            col   <= COORD_W'(div_res.rem) + xo16;
            row   <= div_res.quot + COORD_W'(row_base);
            k     <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rect.valid      <= 1'b1;
            rect.x_start    <= r_xs;
            rect.y_start    <= r_ys;
            rect.x_end      <= r_xe;
            rect.y_end      <= r_ye;
            rect.fill_color <= color;
            rect.last_rect  <= is_last;
            if (is_last) begin
              prev_col <= col;
              prev_row <= row;
              state    <= S_IDLE;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RLERECT_ASSERT_NOW(a_done_in_divide, clk, rst, div_res.done, state == S_DIVIDE)
  `RLERECT_ASSERT_NOW(a_k_in_range, clk, rst, state == S_EMIT, k <= n_last)
  `RLERECT_ASSERT_NEXT(a_xfer_starts_div, clk, rst, run_xfer, state == S_DIVIDE)
  `RLERECT_ASSERT_NEXT(a_last_ends_run, clk, rst,
                       state == S_EMIT && out_free && is_last, state == S_IDLE && rect.last_rect)

endmodule

`default_nettype wire

// File: tb/fill_rect_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fill-rectangle checker
// Watches the register port and both channels of the run-length converter.
// Every accepted run is traced to its fill rectangles. Every rectangle transfer
// is compared field by field against the oldest rectangle still owed.
// ----------------------------------------------------------------------------

module fill_rect_checker import rlerect_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rlerect_run_if               run,
  rlerect_rect_if              rect,
  output int                   errors,
  output int                   outstanding
);

  typedef struct packed {
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COLOR_W-1:0] color;
    logic               last;
  } fill_rect_t;

  fill_rect_t pending_rects[$];

  logic [CFG_W-1:0]   line_width;
  logic [CFG_W-1:0]   col_base;
  logic [CFG_W-1:0]   row_base;
  logic [TOTAL_W-1:0] pixel_total;
  logic [COORD_W-1:0] prev_col;
  logic [COORD_W-1:0] prev_row;

  function automatic void add_rect(logic [COORD_W-1:0] xs, logic [COORD_W-1:0] ys,
                                   logic [COORD_W-1:0] xe, logic [COORD_W-1:0] ye,
                                   logic [COLOR_W-1:0] color, logic last);
    pending_rects.push_back('{xs: xs, ys: ys, xe: xe, ye: ye, color: color, last: last});
  endfunction

  function automatic void trace_run(logic start, logic [COLOR_W-1:0] color,
                                    logic [RUN_W-1:0] len);
    logic [TOTAL_W-1:0] w;
    logic [TOTAL_W-1:0] xo;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] row_start;
    w = (line_width == '0) ? 32'd1 : {22'd0, line_width};
    xo = {22'd0, col_base};
    row_start = {6'd0, col_base};
    if (start) begin
      pixel_total = '0;
      prev_col = {6'd0, col_base};
      prev_row = {6'd0, row_base};
    end
    pixel_total = pixel_total + {16'd0, len};
    col = COORD_W'((pixel_total % w) + xo);
    row = COORD_W'((pixel_total / w) + {22'd0, row_base});
    right_col = COORD_W'(w - 32'd1 + xo);
    if (row > prev_row) begin
      if ({1'b0, row} > {1'b0, prev_row} + 17'd1) begin
        add_rect(prev_col, prev_row, right_col, prev_row, color, 1'b0);
        add_rect(row_start, prev_row + 16'd1, right_col, row - 16'd1, color, 1'b0);
        add_rect(row_start, row, col, row, color, 1'b1);
      end else begin
        add_rect(prev_col, prev_row, right_col, row - 16'd1, color, 1'b0);
        add_rect(row_start, row, col, row, color, 1'b1);
      end
    end else begin
      add_rect(prev_col, prev_row, col, row, color, 1'b1);
    end
    prev_col = col;
    prev_row = row;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    fill_rect_t want;
    if (rst) begin
      line_width = LINE_WIDTH_RESET;
      col_base = '0;
      row_base = '0;
      pixel_total = '0;
      prev_col = '0;
      prev_row = '0;
      pending_rects.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LINE_WIDTH: line_width = cfg_data;
          CFG_COL_BASE:   col_base = cfg_data;
          CFG_ROW_BASE:   row_base = cfg_data;
          default: ;
        endcase
      end
      if (run.valid && run.ready) begin
        trace_run(run.start_image, run.pixel_color, run.run_length);
      end
      if (rect.valid && rect.ready) begin
        if (pending_rects.size() == 0) begin
          $display("%0t: rectangle expected none, got %h %h %h %h color %h last %b",
                   $time, rect.x_start, rect.y_start, rect.x_end, rect.y_end,
                   rect.fill_color, rect.last_rect);
          errors++;
        end else begin
          want = pending_rects.pop_front();
          compare_field("x_start", want.xs, rect.x_start);
          compare_field("y_start", want.ys, rect.y_start);
          compare_field("x_end", want.xe, rect.x_end);
          compare_field("y_end", want.ye, rect.y_end);
          compare_field("fill_color", want.color, rect.fill_color);
          compare_field("last_rect", {15'd0, want.last}, {15'd0, rect.last_rect});
        end
      end
    end
    outstanding <= pending_rects.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Run-length to fill-rectangle converter testbench
// Drives run records and register writes into the converter under random
// idling on both channels. Directed runs cover the row cases, zero runs,
// zero width, row wrap and the extreme offsets. Random image phases follow,
// each with its own geometry. The checker owns the prediction.
// ----------------------------------------------------------------------------

module testbench import rlerect_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   outstanding;
  bit                   src_idle;
  bit                   snk_idle;
  int                   stall_left;
  int                   width_now;

  rlerect_run_if  run_ch ();
  rlerect_rect_if rect_ch ();

  rle_runs_to_fill_rectangles_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .run       (run_ch),
    .rect      (rect_ch)
  );

  fill_rect_checker fill_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .run         (run_ch),
    .rect        (rect_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // With sink idling on, the rectangle side often stalls for a fresh random count after a transfer.
  always @(posedge clk) begin
    if (rst) begin
      rect_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (rect_ch.valid && rect_ch.ready) begin
      if (snk_idle && $urandom_range(0, 12) != 0) begin
        rect_ch.ready <= 1'b0;
        stall_left <= $urandom_range(1, 12);
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) rect_ch.ready <= 1'b1;
    end else begin
      rect_ch.ready <= 1'b1;
    end
  end

  task automatic program_geometry(int w, int xo, int yo);
    cfg_write <= 1'b1;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= CFG_COL_BASE;
    cfg_data <= CFG_W'(xo);
    @(posedge clk);
    cfg_index <= CFG_ROW_BASE;
    cfg_data <= CFG_W'(yo);
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    width_now = (w == 0) ? 1 : w;
  endtask

  task automatic drain();
    run_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_run(bit start, logic [COLOR_W-1:0] color, logic [RUN_W-1:0] len,
                          bit hold);
    int gap;
    gap = src_idle ? $urandom_range(0, 12) : 0;
    if (hold) drain();
    else if (gap != 0) run_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk);
    run_ch.valid <= 1'b1;
    run_ch.start_image <= start;
    run_ch.pixel_color <= color;
    run_ch.run_length <= len;
    @(posedge clk);
    while (!run_ch.ready) @(posedge clk);
  endtask

  function automatic logic [RUN_W-1:0] pick_run_length();
    int lo;
    int hi;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      lo = 0;
      hi = width_now - 1;
    end else if (pick < 50) begin
      lo = width_now / 2;
      hi = 2 * width_now;
    end else if (pick < 70) begin
      lo = 2 * width_now;
      hi = 8 * width_now;
    end else if (pick < 80) begin
      return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    end else begin
      lo = 0;
      hi = 65535;
    end
    if (hi > 65535) hi = 65535;
    if (lo > hi) lo = hi;
    return RUN_W'($urandom_range(lo, hi));
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  initial begin
    int w;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_LINE_WIDTH;
    cfg_data = '0;
    run_ch.valid = 1'b0;
    run_ch.start_image = 1'b0;
    run_ch.pixel_color = '0;
    run_ch.run_length = '0;
    src_idle = 1'b0;
    snk_idle = 1'b0;
    width_now = LINE_WIDTH_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: zero run, same row, one boundary, several rows.
    send_run(1'b1, 16'h0000, 16'd0, 1'b0);
    send_run(1'b0, 16'hFFFF, 16'd100, 1'b0);
    send_run(1'b0, 16'hA5A5, 16'd380, 1'b0);
    send_run(1'b0, 16'h5A5A, 16'd1500, 1'b0);
    send_run(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    drain();
    repeat (4) @(posedge clk);

    // Zero width acts as one pixel per row; long runs wrap the row.
    program_geometry(0, 1023, 1023);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_run(1'b1, 16'h0000, 16'd0, 1'b0);
    send_run(1'b0, 16'h1234, 16'd1, 1'b0);
    send_run(1'b0, 16'hFFFF, 16'd1, 1'b0);
    send_run(1'b0, 16'hA5A5, 16'hFFFF, 1'b0);
    send_run(1'b0, 16'h5A5A, 16'hFFFF, 1'b1);
    drain();
    repeat (4) @(posedge clk);

    program_geometry(1023, 1023, 0);
    send_run(1'b1, 16'hFFFF, 16'd1022, 1'b0);
    send_run(1'b0, 16'h0000, 16'd1, 1'b0);
    send_run(1'b0, 16'hA5A5, 16'hFFFF, 1'b0);
    send_run(1'b0, 16'h5A5A, 16'd0, 1'b0);
    send_run(1'b1, 16'hFFFF, 16'd2046, 1'b0);
    drain();
    repeat (4) @(posedge clk);

    program_geometry(1, 0, 0);
    send_run(1'b1, 16'h0000, 16'd0, 1'b0);
    send_run(1'b0, 16'hFFFF, 16'd1, 1'b0);
    send_run(1'b0, 16'hA5A5, 16'd2, 1'b0);
    send_run(1'b0, 16'h5A5A, 16'hFFFF, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      repeat (4) @(posedge clk);
      case ($urandom_range(0, 4))
        0: w = 1;
        1: w = 1023;
        2: w = $urandom_range(2, 16);
        3: w = $urandom_range(1, 1023);
        default: w = 0;
      endcase
      program_geometry(w, pick_offset(), pick_offset());
      if (phase == 0) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end else if (phase == 1) begin
        src_idle = 1'b1;
        snk_idle = 1'b1;
      end else begin
        src_idle = $urandom_range(0, 1);
        snk_idle = $urandom_range(0, 1);
      end
      for (int i = 0; i < 42; i++) begin
        send_run(i == 0 || $urandom_range(0, 29) == 0, COLOR_W'($urandom),
                 pick_run_length(), $urandom_range(0, 24) == 0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rlerect_pkg.sv
rtl/rlerect_if.sv
rtl/rlerect_div.sv
rtl/rle_runs_to_fill_rectangles_top.sv
tb/fill_rect_checker.sv
tb/testbench.sv
